// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// cond must be true in the cycle after trig
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed: next-cycle check");
// cond must be true in the same cycle as trig
`define ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed: same-cycle check");
`else
`define ASSERT_NEXT(label, clk, rst_n, trig, cond)
`define ASSERT_SAME(label, clk, rst_n, trig, cond)
`endif

`endif

// ===== rtl/srp_pkg.sv =====
package srp_pkg;

    localparam int MAX_DATAGRAM = 1024;
    localparam int CNT_W        = $clog2(MAX_DATAGRAM + 1);
    localparam int HDR_BYTES    = 20;

    localparam logic [15:0] RESP_TYPE_RESET = 16'h0101;

    localparam logic [15:0] AT_MAPPED     = 16'h0001;
    localparam logic [15:0] AT_CHANGED    = 16'h0005;
    localparam logic [15:0] AT_USERNAME   = 16'h0006;
    localparam logic [15:0] AT_XOR_MAPPED = 16'h0020;
    localparam logic [15:0] AT_OTHER      = 16'h802C;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_ATTR   = 2'd1,
        PH_SKIP   = 2'd2
    } srp_phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_NOT_RESP = 2'd2,
        ST_TRUNC    = 2'd3
    } srp_status_t;

    typedef struct packed {
        logic step;
        logic last;
    } srp_ctrl_t;

    typedef struct packed {
        srp_status_t status;
        logic [15:0] message_type;
        logic [31:0] magic_cookie;
        logic [31:0] tid_high;
        logic [63:0] tid_low;
        logic        mapped_valid;
        logic [15:0] mapped_port;
        logic [31:0] mapped_ip;
        logic        changed_valid;
        logic [15:0] changed_port;
        logic [31:0] changed_ip;
        logic        username_seen;
    } srp_result_t;

endpackage

// ===== rtl/srp_byte_if.sv =====
interface srp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/srp_summary_if.sv =====
interface srp_summary_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] message_type;
    logic [31:0] magic_cookie;
    logic [31:0] tid_high;
    logic [63:0] tid_low;
    logic        mapped_valid;
    logic [15:0] mapped_port;
    logic [31:0] mapped_ip;
    logic        changed_valid;
    logic [15:0] changed_port;
    logic [31:0] changed_ip;
    logic        username_seen;

    modport source (
        output valid, output status, output message_type, output magic_cookie,
        output tid_high, output tid_low, output mapped_valid, output mapped_port,
        output mapped_ip, output changed_valid, output changed_port, output changed_ip,
        output username_seen, input ready
    );
    modport sink (
        input valid, input status, input message_type, input magic_cookie,
        input tid_high, input tid_low, input mapped_valid, input mapped_port,
        input mapped_ip, input changed_valid, input changed_port, input changed_ip,
        input username_seen, output ready
    );
endinterface

// ===== rtl/stun_response_parser_unit.sv =====
// Latency: the summary is valid in the cycle after the transfer of the last byte.
// Throughput: one byte per cycle while the summary slot is free for a last byte;
// the byte walk is a single pass between the packet state and summary registers.
// A byte that is not the last is taken even while a summary waits downstream.
// Reset (rst_n low, asynchronous): packet state cleared, no summary pending,
// response type register back to 0x0101.
`include "assert_macros.svh"

module stun_response_parser_unit
    import srp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_data,
    srp_byte_if.sink      rx,
    srp_summary_if.source summary
);

    // Message type whose attributes get walked; the user must write it only while idle (not enforced here).
    logic [15:0] resp_type_reg;

    // Output register: holds one summary until the sink takes it.
    logic        out_valid_reg, out_valid_next;
    srp_result_t out_reg;

    srp_ctrl_t   ctrl;
    srp_result_t core_result;
    logic        out_free;
    logic        short_bare;

    // A slot is free when empty or being drained this cycle. Only a last byte
    // needs the slot, so plain bytes keep flowing behind a stalled summary.
    assign out_free  = !out_valid_reg || summary.ready;
    assign rx.ready  = out_free || !rx.last_byte;
    assign ctrl.step = rx.valid && rx.ready;
    assign ctrl.last = rx.last_byte;

    srp_parse_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .data_byte     (rx.data_byte),
        .response_type (resp_type_reg),
        .result        (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            resp_type_reg <= RESP_TYPE_RESET;
        else if (cfg_we)
            resp_type_reg <= cfg_data;
    end

    // Advance the output slot: load on a last-byte transfer, drop on a
    // summary transfer, hold otherwise.
    always_comb
    begin
        priority if (ctrl.step && ctrl.last)
            out_valid_next = 1'b1;
        else if (summary.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step && ctrl.last)
            out_reg <= core_result;
    end

    assign summary.valid         = out_valid_reg;
    assign summary.status        = out_reg.status;
    assign summary.message_type  = out_reg.message_type;
    assign summary.magic_cookie  = out_reg.magic_cookie;
    assign summary.tid_high      = out_reg.tid_high;
    assign summary.tid_low       = out_reg.tid_low;
    assign summary.mapped_valid  = out_reg.mapped_valid;
    assign summary.mapped_port   = out_reg.mapped_port;
    assign summary.mapped_ip     = out_reg.mapped_ip;
    assign summary.changed_valid = out_reg.changed_valid;
    assign summary.changed_port  = out_reg.changed_port;
    assign summary.changed_ip    = out_reg.changed_ip;
    assign summary.username_seen = out_reg.username_seen;

    // No address, no type: what a short datagram must look like.
    assign short_bare = !summary.mapped_valid && !summary.changed_valid
                        && summary.message_type == 16'd0;

    // A last-byte transfer always yields a summary in the next cycle.
    `ASSERT_NEXT(a_last_gives_summary, clk, rst_n, ctrl.step && ctrl.last, summary.valid)
    // A plain byte with the slot empty never creates a summary.
    `ASSERT_NEXT(a_plain_no_summary, clk, rst_n, ctrl.step && !ctrl.last && !summary.valid, !summary.valid)
    // A short datagram reports nothing beyond its status.
    `ASSERT_SAME(a_short_is_bare, clk, rst_n, summary.valid && summary.status == ST_SHORT, short_bare)
    // A last byte is refused only while a summary is stuck downstream.
    `ASSERT_SAME(a_stall_reason, clk, rst_n, !rx.ready, !out_free && rx.last_byte)

endmodule

// ===== rtl/srp_parse_core.sv =====
module srp_parse_core
    import srp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  srp_ctrl_t   ctrl,
    input  logic [7:0]  data_byte,
    input  logic [15:0] response_type,
    output srp_result_t result
);

    // control state
    logic [CNT_W-1:0] count_reg, count_next;
    srp_phase_t       phase_reg, phase_next;
    logic [CNT_W-1:0] off_reg, off_next;
    logic             user_reg, user_next;
    logic             xor_v_reg, xor_v_next;
    logic             plain_v_reg, plain_v_next;
    logic             other_v_reg, other_v_next;

    // payload state
    logic [15:0] type_reg, type_next;
    logic [31:0] cookie_reg, cookie_next;
    logic [95:0] tid_reg, tid_next;
    logic [15:0] atype_reg, atype_next;
    logic [15:0] alen_reg, alen_next;
    logic [7:0]  val_reg [0:5];
    logic [7:0]  val_next [0:5];
    logic [47:0] xor_reg, xor_next;
    logic [47:0] plain_reg, plain_next;
    logic [47:0] other_reg, other_next;

    logic             take;
    logic [CNT_W-1:0] off_m4;
    logic [2:0]       vidx;
    logic [2:0]       vslot;
    logic [CNT_W-1:0] off_inc;
    logic [17:0]      off_inc_x;
    logic [17:0]      end_val;
    logic [17:0]      padded;
    logic [17:0]      trunc_end;
    logic             finish;
    logic [7:0]       vcur [0:5];
    logic [15:0]      port_cur;
    logic [31:0]      ip_cur;
    logic             use_xor;

    always_comb
    begin
        count_next   = count_reg;
        phase_next   = phase_reg;
        off_next     = off_reg;
        user_next    = user_reg;
        xor_v_next   = xor_v_reg;
        plain_v_next = plain_v_reg;
        other_v_next = other_v_reg;
        type_next    = type_reg;
        cookie_next  = cookie_reg;
        tid_next     = tid_reg;
        atype_next   = atype_reg;
        alen_next    = alen_reg;
        val_next     = val_reg;
        xor_next     = xor_reg;
        plain_next   = plain_reg;
        other_next   = other_reg;

        take      = ctrl.step && (count_reg < CNT_W'(MAX_DATAGRAM));
        off_m4    = off_reg - CNT_W'(4);
        vidx      = off_m4[2:0];
        vslot     = 3'(vidx - 3'd2);
        off_inc   = off_reg + CNT_W'(1);
        off_inc_x = 18'(off_inc);
        end_val   = 18'd0;
        padded    = 18'd0;
        finish    = 1'b0;
        vcur      = val_reg;
        port_cur  = 16'd0;
        ip_cur    = 32'd0;

        if (take)
        begin
            count_next = count_reg + CNT_W'(1);
            unique case (phase_reg)
                PH_HEADER:
                begin
                    priority if (count_reg == CNT_W'(0))
                        type_next = {data_byte, 8'h00};
                    else if (count_reg == CNT_W'(1))
                        type_next = {type_reg[15:8], data_byte};
                    else if (count_reg >= CNT_W'(4) && count_reg < CNT_W'(8))
                        cookie_next = {cookie_reg[23:0], data_byte};
                    else if (count_reg >= CNT_W'(8) && count_reg < CNT_W'(HDR_BYTES))
                        tid_next = {tid_reg[87:0], data_byte};
                    else
                        type_next = type_reg;
                    if (count_reg == CNT_W'(HDR_BYTES - 1))
                        phase_next = (type_reg == response_type) ? PH_ATTR : PH_SKIP;
                end
                PH_ATTR:
                begin
                    // capture the attribute header or value bytes 2 to 7 (port and address)
                    if (off_reg < CNT_W'(4))
                    begin
                        unique case (off_reg[1:0])
                            2'd0:    atype_next = {data_byte, 8'h00};
                            2'd1:    atype_next = {atype_reg[15:8], data_byte};
                            2'd2:    alen_next  = {data_byte, 8'h00};
                            default: alen_next  = {alen_reg[15:8], data_byte};
                        endcase
                    end
                    else if (off_m4 < CNT_W'(8) && vidx >= 3'd2)
                    begin
                        val_next[vslot] = data_byte;
                        vcur[vslot]     = data_byte;
                    end

                    end_val  = 18'd4 + 18'(alen_next);
                    padded   = 18'd4 + ((18'(alen_next) + 18'd3) & ~18'd3);
                    finish   = (off_inc_x >= 18'd4) && (off_inc_x == end_val);
                    port_cur = {vcur[0], vcur[1]};
                    ip_cur   = {vcur[2], vcur[3], vcur[4], vcur[5]};

                    if (finish)
                    begin
                        if (atype_next == AT_USERNAME)
                            user_next = 1'b1;
                        else if (alen_next >= 16'd8)
                        begin
                            // keep the first of each kind
                            if (atype_next == AT_XOR_MAPPED && !xor_v_reg)
                            begin
                                xor_v_next = 1'b1;
                                xor_next   = {port_cur ^ cookie_reg[31:16], ip_cur ^ cookie_reg};
                            end
                            else if (atype_next == AT_MAPPED && !plain_v_reg)
                            begin
                                plain_v_next = 1'b1;
                                plain_next   = {port_cur, ip_cur};
                            end
                            else if ((atype_next == AT_CHANGED || atype_next == AT_OTHER)
                                     && !other_v_reg)
                            begin
                                other_v_next = 1'b1;
                                other_next   = {port_cur, ip_cur};
                            end
                        end
                    end

                    if (off_inc_x >= 18'd4 && off_inc_x >= padded)
                        off_next = '0;
                    else
                        off_next = off_inc;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // summary built from the state after this byte
    always_comb
    begin
        trunc_end = 18'd4 + 18'(alen_next);
        use_xor   = xor_v_next;
        result    = '0;
        if (phase_next == PH_HEADER)
            result.status = ST_SHORT;
        else
        begin
            if (phase_next == PH_SKIP)
                result.status = ST_NOT_RESP;
            else if (off_next != '0 && 18'(off_next) < trunc_end)
                result.status = ST_TRUNC;
            else
                result.status = ST_OK;
            result.message_type  = type_next;
            result.magic_cookie  = cookie_next;
            result.tid_high      = tid_next[95:64];
            result.tid_low       = tid_next[63:0];
            result.mapped_valid  = xor_v_next || plain_v_next;
            if (use_xor)
            begin
                result.mapped_port = xor_next[47:32];
                result.mapped_ip   = xor_next[31:0];
            end
            else if (plain_v_next)
            begin
                result.mapped_port = plain_next[47:32];
                result.mapped_ip   = plain_next[31:0];
            end
            result.changed_valid = other_v_next;
            if (other_v_next)
            begin
                result.changed_port = other_next[47:32];
                result.changed_ip   = other_next[31:0];
            end
            result.username_seen = user_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            phase_reg   <= PH_HEADER;
            off_reg     <= '0;
            user_reg    <= 1'b0;
            xor_v_reg   <= 1'b0;
            plain_v_reg <= 1'b0;
            other_v_reg <= 1'b0;
        end
        else if (ctrl.step && ctrl.last)
        begin
            // drop the packet state once the summary is out
            count_reg   <= '0;
            phase_reg   <= PH_HEADER;
            off_reg     <= '0;
            user_reg    <= 1'b0;
            xor_v_reg   <= 1'b0;
            plain_v_reg <= 1'b0;
            other_v_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            off_reg     <= off_next;
            user_reg    <= user_next;
            xor_v_reg   <= xor_v_next;
            plain_v_reg <= plain_v_next;
            other_v_reg <= other_v_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg   <= '0;
            cookie_reg <= '0;
            tid_reg    <= '0;
            atype_reg  <= '0;
            alen_reg   <= '0;
            val_reg    <= '{default: '0};
            xor_reg    <= '0;
            plain_reg  <= '0;
            other_reg  <= '0;
        end
        else
        begin
            type_reg   <= type_next;
            cookie_reg <= cookie_next;
            tid_reg    <= tid_next;
            atype_reg  <= atype_next;
            alen_reg   <= alen_next;
            val_reg    <= val_next;
            xor_reg    <= xor_next;
            plain_reg  <= plain_next;
            other_reg  <= other_next;
        end
    end

endmodule

// ===== verif/tb.sv =====
module tb;
    import srp_pkg::*;

    // One decoded IPv4 transport address as the parser keeps it.
    typedef struct packed {
        logic        found;
        logic [15:0] port;
        logic [31:0] ip;
    } ipv4_addr_t;

    localparam logic [31:0] STUN_COOKIE = 32'h2112A442;
    localparam logic [15:0] AT_UNKNOWN  = 16'h8028;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [15:0] cfg_data = '0;

    srp_byte_if    rx_if();
    srp_summary_if sum_if();

    stun_response_parser_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .rx      (rx_if),
        .summary (sum_if)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Run bookkeeping and idle control
    // ------------------------------------------------------------------
    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int hold_len       = 0;   // length of the next hold-off, in cycles
    int hold_req_count = 0;   // bumped by a test to ask for a hold-off
    int hold_req_taken = 0;   // requests already picked up by the summary side
    int hold_left      = 0;
    int bytes_sent     = 0;
    int datagrams_sent = 0;
    int summaries_seen = 0;
    int cfg_writes     = 0;
    int mismatch_count = 0;

    // Datagram under construction, sent byte by byte.
    logic [7:0] pkt [$];

    // Expected summaries, oldest first.
    srp_result_t pending_summaries [$];
    srp_result_t want;

    // ------------------------------------------------------------------
    // Parser shadow: response type register plus per-datagram state
    // ------------------------------------------------------------------
    logic [15:0] parse_resp_type;
    int unsigned p_count;
    logic [15:0] p_type;
    logic [31:0] p_cookie;
    logic [7:0]  p_tid [12];
    srp_phase_t  p_phase;
    logic [15:0] p_atype;
    logic [15:0] p_alen;
    int unsigned p_aoff;
    logic [7:0]  p_val [8];
    ipv4_addr_t  p_xor;
    ipv4_addr_t  p_plain;
    ipv4_addr_t  p_other;
    logic        p_user;

    // Drop all per-datagram state; done at reset and after every summary.
    function automatic void clear_datagram();
        p_count  = 0;
        p_type   = '0;
        p_cookie = '0;
        foreach (p_tid[i])
            p_tid[i] = '0;
        p_phase  = PH_HEADER;
        p_atype  = '0;
        p_alen   = '0;
        p_aoff   = 0;
        foreach (p_val[i])
            p_val[i] = '0;
        p_xor    = '0;
        p_plain  = '0;
        p_other  = '0;
        p_user   = 1'b0;
    endfunction

    // Advance the shadow by one transferred byte; on the last byte queue the
    // summary the block must produce.
    function automatic void parse_byte(input logic [7:0] b, input logic lst);
        srp_result_t r;
        ipv4_addr_t  mapped;
        int unsigned off;
        int unsigned alen;
        logic [15:0] port;
        logic [31:0] ip;
        // Bytes past the datagram size limit are dropped unparsed.
        if (p_count < MAX_DATAGRAM)
        begin
            if (p_phase == PH_HEADER)
            begin
                if (p_count == 0)
                    p_type[15:8] = b;
                else if (p_count == 1)
                    p_type[7:0] = b;
                else if (p_count >= 4 && p_count < 8)
                    p_cookie = {p_cookie[23:0], b};
                else if (p_count >= 8 && p_count < HDR_BYTES)
                    p_tid[p_count - 8] = b;
                // The header decides whether attributes get walked at all.
                if (p_count == HDR_BYTES - 1)
                    p_phase = (p_type == parse_resp_type) ? PH_ATTR : PH_SKIP;
            end
            else if (p_phase == PH_ATTR)
            begin
                off = p_aoff;
                case (off)
                    0: p_atype = {b, 8'h00};
                    1: p_atype[7:0] = b;
                    2: p_alen = {b, 8'h00};
                    3: p_alen[7:0] = b;
                    default:
                        if (off < 12)
                            p_val[off - 4] = b;
                endcase
                off++;
                alen = p_alen;
                // Close the attribute once its value is complete; the first
                // of each address kind wins, short address values are ignored.
                if (off >= 4 && off == 4 + alen && p_atype == AT_USERNAME)
                    p_user = 1'b1;
                else if (off >= 4 && off == 4 + alen && alen >= 8)
                begin
                    port = {p_val[2], p_val[3]};
                    ip   = {p_val[4], p_val[5], p_val[6], p_val[7]};
                    if (p_atype == AT_XOR_MAPPED && !p_xor.found)
                        p_xor = '{1'b1, port ^ p_cookie[31:16], ip ^ p_cookie};
                    else if (p_atype == AT_MAPPED && !p_plain.found)
                        p_plain = '{1'b1, port, ip};
                    else if ((p_atype == AT_CHANGED || p_atype == AT_OTHER) && !p_other.found)
                        p_other = '{1'b1, port, ip};
                end
                // Skip the padding up to the next 4-byte boundary.
                if (off >= 4 && off >= 4 + ((alen + 3) & ~32'd3))
                begin
                    off = 0;
                    foreach (p_val[i])
                        p_val[i] = '0;
                end
                p_aoff = off;
            end
            p_count++;
        end

        if (lst)
        begin
            r = '0;
            if (p_phase == PH_HEADER)
                r.status = ST_SHORT;
            else
            begin
                if (p_phase == PH_SKIP)
                    r.status = ST_NOT_RESP;
                else if (p_aoff != 0 && p_aoff < 4 + p_alen)
                    r.status = ST_TRUNC;
                else
                    r.status = ST_OK;
                mapped          = p_xor.found ? p_xor : p_plain;
                r.message_type  = p_type;
                r.magic_cookie  = p_cookie;
                r.tid_high      = {p_tid[0], p_tid[1], p_tid[2], p_tid[3]};
                r.tid_low       = {p_tid[4], p_tid[5], p_tid[6], p_tid[7],
                                   p_tid[8], p_tid[9], p_tid[10], p_tid[11]};
                r.mapped_valid  = mapped.found;
                r.mapped_port   = mapped.port;
                r.mapped_ip     = mapped.ip;
                r.changed_valid = p_other.found;
                r.changed_port  = p_other.port;
                r.changed_ip    = p_other.ip;
                r.username_seen = p_user;
            end
            pending_summaries.insert(pending_summaries.size(), r);
            clear_datagram();
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic void report_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("ERROR: %s", msg);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (act_v !== exp_v)
            report_failure($sformatf("summary %0d %s: expected 0x%0h, got 0x%0h",
                                     summaries_seen, name, exp_v, act_v));
    endfunction

    // Sample every summary transfer at the rising edge and match it against
    // the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && sum_if.valid && sum_if.ready)
        begin
            summaries_seen++;
            if (pending_summaries.size() == 0)
                report_failure($sformatf("summary %0d arrived with none expected",
                                         summaries_seen));
            else
            begin
                want = pending_summaries.pop_front();
                check_field("status",        64'(want.status),        64'(sum_if.status));
                check_field("message_type",  64'(want.message_type),  64'(sum_if.message_type));
                check_field("magic_cookie",  64'(want.magic_cookie),  64'(sum_if.magic_cookie));
                check_field("tid_high",      64'(want.tid_high),      64'(sum_if.tid_high));
                check_field("tid_low",       want.tid_low,            sum_if.tid_low);
                check_field("mapped_valid",  64'(want.mapped_valid),  64'(sum_if.mapped_valid));
                check_field("mapped_port",   64'(want.mapped_port),   64'(sum_if.mapped_port));
                check_field("mapped_ip",     64'(want.mapped_ip),     64'(sum_if.mapped_ip));
                check_field("changed_valid", 64'(want.changed_valid), 64'(sum_if.changed_valid));
                check_field("changed_port",  64'(want.changed_port),  64'(sum_if.changed_port));
                check_field("changed_ip",    64'(want.changed_ip),    64'(sum_if.changed_ip));
                check_field("username_seen", 64'(want.username_seen), 64'(sum_if.username_seen));
            end
        end
    end

    // ------------------------------------------------------------------
    // Summary side: random ready, or a long hold-off when a test asks for one
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req_count != hold_req_taken)
        begin
            hold_left      = hold_len;
            hold_req_taken = hold_req_count;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            sum_if.ready <= 1'b0;
        end
        else
            sum_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------

    // Offer one byte, with random idle cycles ahead of it, and hold it until
    // the transfer happens.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_if.valid     <= 1'b0;
            rx_if.data_byte <= 8'($urandom_range(255));
            @(negedge clk);
        end
        rx_if.valid     <= 1'b1;
        rx_if.data_byte <= b;
        rx_if.last_byte <= lst;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        parse_byte(b, lst);
        bytes_sent++;
    endtask

    // Send the first n bytes of the built datagram (all of it for n <= 0 or n past its end),
    // marking the final one as last.
    task automatic send_pkt(input int n);
        if (n <= 0 || n > pkt.size())
            n = pkt.size();
        for (int i = 0; i < n; i++)
            send_byte(pkt[i], i == n - 1);
        datagrams_sent++;
    endtask

    // Drop valid, wait for every expected summary, then let the pipe settle.
    task automatic drain();
        @(negedge clk);
        rx_if.valid <= 1'b0;
        while (pending_summaries.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the response type only while the parser is idle.
    task automatic write_response_type(input logic [15:0] v);
        drain();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        parse_resp_type = v;
        cfg_writes++;
    endtask

    // Add one byte at the tail of the datagram under construction.
    function automatic void append_byte(input logic [7:0] v);
        pkt.insert(pkt.size(), v);
    endfunction

    function automatic void put16(input logic [15:0] v);
        append_byte(v[15:8]);
        append_byte(v[7:0]);
    endfunction

    function automatic void put32(input logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endfunction

    // Start a new datagram with a 20-byte header; the length field is junk
    // since the parser ignores it.
    function automatic void start_header(input logic [15:0] mtype, input logic [31:0] cookie,
                                         input logic [95:0] tid);
        pkt.delete();
        put16(mtype);
        put16(16'($urandom_range(65535)));
        put32(cookie);
        put32(tid[95:64]);
        put32(tid[63:32]);
        put32(tid[31:0]);
    endfunction

    // Attribute with random value bytes, padded to a multiple of 4 bytes.
    function automatic void put_attr(input logic [15:0] atype, input int len);
        put16(atype);
        put16(len[15:0]);
        for (int i = 0; i < ((len + 3) & ~3); i++)
            append_byte(8'($urandom_range(255)));
    endfunction

    // Address attribute with an 8-byte IPv4 value.
    function automatic void put_addr(input logic [15:0] atype, input logic [15:0] port,
                                     input logic [31:0] ip);
        put16(atype);
        put16(16'd8);
        append_byte(8'($urandom_range(255)));
        append_byte(8'h01);
        put16(port);
        put32(ip);
    endfunction

    function automatic logic [95:0] random_tid();
        return {$urandom, $urandom, $urandom};
    endfunction

    // Mostly well-formed responses with random attribute mixes; the rest is
    // foreign types, raw noise, cut-off datagrams and wild length fields.
    task automatic send_random_datagram();
        int          roll;
        int          n_attr;
        int          kind;
        int          len;
        int          cut;
        logic [15:0] mtype;
        logic [31:0] cookie;
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            pkt.delete();
            len = $urandom_range(1, 48);
            repeat (len) append_byte(8'($urandom_range(255)));
            send_pkt(0);
            return;
        end
        mtype  = (roll < 88) ? parse_resp_type : 16'($urandom_range(65535));
        cookie = ($urandom_range(99) < 60) ? STUN_COOKIE : $urandom;
        start_header(mtype, cookie, random_tid());
        n_attr = $urandom_range(0, 4);
        for (int a = 0; a < n_attr; a++)
        begin
            kind = $urandom_range(0, 7);
            len  = ($urandom_range(9) < 7) ? 8 : $urandom_range(0, 16);
            case (kind)
                0: put_attr(AT_MAPPED, len);
                1, 6: put_attr(AT_XOR_MAPPED, len);
                2: put_attr(AT_CHANGED, len);
                3: put_attr(AT_OTHER, len);
                4: put_attr(AT_USERNAME, $urandom_range(0, 12));
                5: put_attr(16'($urandom_range(65535)), $urandom_range(0, 16));
                default:
                begin
                    // random type and length, then up to 8 value bytes and no further attributes
                    put16(16'($urandom_range(65535)));
                    put16(16'($urandom_range(65535)));
                    repeat ($urandom_range(0, 8)) append_byte(8'($urandom_range(255)));
                    break;
                end
            endcase
        end
        cut = ($urandom_range(99) < 15) ? $urandom_range(1, pkt.size()) : 0;
        send_pkt(cut);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Datagrams too short for a header, a foreign type, and a bare response
    // header, all under the reset value of the response type.
    task automatic test_short_and_foreign();
        pkt.delete();
        append_byte(8'hFF);
        send_pkt(0);
        start_header(RESP_TYPE_RESET, STUN_COOKIE, random_tid());
        send_pkt(HDR_BYTES - 1);
        start_header(16'h0111, 32'hFFFF_FFFF, {96{1'b1}});
        put_addr(AT_MAPPED, 16'h1234, 32'h0A00_0001);
        send_pkt(0);
        start_header(RESP_TYPE_RESET, 32'h0000_0000, {96{1'b0}});
        send_pkt(0);
    endtask

    // Every address kind, the XOR unmask, first-of-kind wins, username, short
    // address values, unknown attributes and the plain fallback.
    task automatic test_address_attributes();
        start_header(RESP_TYPE_RESET, STUN_COOKIE, random_tid());
        put_attr(AT_USERNAME, 5);
        put_addr(AT_MAPPED, 16'h1234, 32'h0A00_0001);
        put_addr(AT_XOR_MAPPED, 16'hFFFF, 32'hFFFF_FFFF);
        put_addr(AT_XOR_MAPPED, 16'h0000, 32'h0000_0000);
        put_addr(AT_OTHER, 16'hABCD, 32'hC0A8_0101);
        put_addr(AT_CHANGED, 16'h5555, 32'h5555_5555);
        put_attr(AT_UNKNOWN, 7);
        send_pkt(0);

        start_header(RESP_TYPE_RESET, STUN_COOKIE, random_tid());
        put_attr(AT_MAPPED, 4);
        put_addr(AT_MAPPED, 16'h0000, 32'h0000_0000);
        put_attr(AT_CHANGED, 12);
        put_attr(AT_USERNAME, 0);
        send_pkt(0);

        start_header(RESP_TYPE_RESET, 32'hFFFF_FFFF, random_tid());
        put_attr(AT_XOR_MAPPED, 4);
        put_addr(AT_XOR_MAPPED, 16'h8001, 32'h7F00_0001);
        put_addr(AT_OTHER, 16'hFFFF, 32'hFFFF_FFFF);
        send_pkt(0);
    endtask

    // Endings inside an attribute header, inside a value, inside padding, and
    // right after an unpadded value.
    task automatic test_truncation();
        start_header(RESP_TYPE_RESET, STUN_COOKIE, random_tid());
        put_addr(AT_MAPPED, 16'h4321, 32'h0102_0304);
        put_attr(AT_OTHER, 8);
        send_pkt(HDR_BYTES + 12 + 2);

        start_header(RESP_TYPE_RESET, STUN_COOKIE, random_tid());
        put_addr(AT_XOR_MAPPED, 16'h0F0F, 32'hF0F0_F0F0);
        put16(AT_UNKNOWN);
        put16(16'd300);
        repeat (10) append_byte(8'($urandom_range(255)));
        send_pkt(0);

        start_header(RESP_TYPE_RESET, STUN_COOKIE, random_tid());
        put_attr(AT_USERNAME, 5);
        send_pkt(HDR_BYTES + 10);

        start_header(RESP_TYPE_RESET, STUN_COOKIE, random_tid());
        put_attr(AT_USERNAME, 5);
        send_pkt(HDR_BYTES + 9);
    endtask

    // Response type register at both extremes, then back to the usual value.
    task automatic test_register_extremes();
        write_response_type(16'h0000);
        start_header(16'h0000, STUN_COOKIE, random_tid());
        put_addr(AT_XOR_MAPPED, 16'h2000, 32'h2112_A443);
        send_pkt(0);
        start_header(RESP_TYPE_RESET, STUN_COOKIE, random_tid());
        put_addr(AT_MAPPED, 16'h0001, 32'h0000_0001);
        send_pkt(0);

        write_response_type(16'hFFFF);
        start_header(16'hFFFF, STUN_COOKIE, random_tid());
        put_addr(AT_OTHER, 16'h0050, 32'hAC10_0001);
        put_attr(AT_USERNAME, 3);
        send_pkt(0);

        write_response_type(RESP_TYPE_RESET);
    endtask

    // Hold the summary side off for a long stretch while bytes keep coming,
    // so a finished summary blocks the next last byte.
    task automatic test_backpressure();
        drain();
        hold_len = 400;
        hold_req_count++;
        repeat (3) send_random_datagram();
    endtask

    // Random datagrams under one idle setting and one response type.
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input logic [15:0] rtype);
        int start_bytes;
        int start_dgrams;
        write_response_type(rtype);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start_bytes   = bytes_sent;
        start_dgrams  = datagrams_sent;
        while (bytes_sent - start_bytes < 150 || datagrams_sent - start_dgrams < 4)
            send_random_datagram();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rx_if.valid     = 1'b0;
        rx_if.data_byte = '0;
        rx_if.last_byte = 1'b0;
        parse_resp_type = RESP_TYPE_RESET;
        clear_datagram();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        src_idle_pct  = 27;
        sink_idle_pct = 49;
        test_short_and_foreign();
        test_address_attributes();
        test_truncation();
        test_register_extremes();
        test_backpressure();

        test_random_traffic(27, 49, RESP_TYPE_RESET);
        test_random_traffic(49, 27, 16'($urandom_range(65535)));
        test_random_traffic(0, 0, 16'($urandom_range(65535)));
        drain();

        $display("Checked %0d summaries from %0d datagrams, %0d bytes, %0d register writes.",
                 summaries_seen, datagrams_sent, bytes_sent, cfg_writes);
        $display("Covered short, foreign and truncated datagrams, every address kind,");
        $display("register extremes, random traffic and a long summary stall.");
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
